// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising edge of clk and is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define DRROB_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen.
`define DRROB_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/drrob_pkg.sv -----
// ----------------------------------------------------------------------------
// drrob_pkg
// Types and constants of the two-wide-retire reorder buffer.
// ----------------------------------------------------------------------------
package drrob_pkg;

  // Default geometry.
  localparam int DEPTH_DEF    = 32;
  localparam int TAG_BASE_DEF = 32;

  // Fixed field widths.
  localparam int TAG_W = 6;
  localparam int REG_W = 5;
  localparam int OCC_W = 6;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_FLUSH  = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_WB     = 2'd2,
    OP_RETIRE = 2'd3
  } drrob_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } drrob_state_t;

  // Input word.
  typedef struct packed {
    drrob_op_t          op;
    logic               writes_register;
    logic               is_branch_instr;
    logic               is_store_instr;
    logic               path_tag;
    logic [REG_W-1:0]   dest_reg;
    logic [TAG_W-1:0]   wb_tag;
    logic               taken_flag;
    logic               retire_slot0_en;
    logic               retire_slot1_en;
  } drrob_req_t;

  // Result word.
  typedef struct packed {
    logic               committed;
    logic               can_retire;
    logic [TAG_W-1:0]   rob_tag;
    logic [REG_W-1:0]   commit_reg;
    logic               rename_commit_en;
    logic               store_release_en;
    logic               branch_commit_en;
    logic               path_select;
    logic               stall_res;
    logic [OCC_W-1:0]   occupancy;
    logic               active_path;
    logic               last;
  } drrob_rsp_t;

  // Fields fixed at allocation, held in the entry memory.
  typedef struct packed {
    logic               wr;
    logic               br;
    logic               st;
    logic               path;
    logic [REG_W-1:0]   rd;
  } drrob_ent_t;

endpackage

// ----- hw/rtl/drrob_ram.sv -----
// ----------------------------------------------------------------------------
// drrob_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module drrob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/drrob_obuf.sv -----
// ----------------------------------------------------------------------------
// drrob_obuf
// Two-word result buffer; loaded only when empty, drained one word a cycle while pop is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drrob_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push1,
  input  logic                 push2,
  input  drrob_pkg::drrob_rsp_t w0,
  input  drrob_pkg::drrob_rsp_t w1,
  input  logic                 pop,
  output logic                 valid,
  output drrob_pkg::drrob_rsp_t word,
  output logic                 empty
);

  logic [1:0]            cnt;
  drrob_pkg::drrob_rsp_t slot0;
  drrob_pkg::drrob_rsp_t slot1;

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push2) begin
      cnt <= 2'd2;
    end else if (push1) begin
      cnt <= 2'd1;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Payload; the second word moves up as the first is taken.
  always_ff @(posedge clk) begin
    if (push1 || push2) begin
      slot0 <= w0;
      slot1 <= w1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign valid = (cnt != 2'd0);
  assign empty = (cnt == 2'd0);
  assign word  = slot0;

  `DRROB_NEVER(a_push_full, (push1 || push2) && !empty, "result buffer loaded while not empty")
  `DRROB_NEVER(a_cnt_range, cnt == 2'd3, "result buffer count out of range")

endmodule

// ----- hw/rtl/dual_retire_reorder_buffer_top.sv -----
// ----------------------------------------------------------------------------
// dual_retire_reorder_buffer_top
// Circular reorder buffer with allocate, writeback, flush and two-wide retire.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation word (flush, allocate, writeback or
//   retire pair); the rsp channel returns one word per operation, two for a
//   retire (head slot first), the final one flagged by last.
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low. req_stall is high while an operation or its results are pending.
//   Allocate, writeback and flush: the word is taken, its result appears the
//   next cycle, and the next word can be taken the cycle after it is drained.
//   Retire: the two head entries are read from the entry memory through its
//   registered read ports, the commit decision is made in the following cycle
//   and two results are queued.
//   The memory read of the head pair sets the retire latency.
//   Reset clears all valid bits, both pointers and the path bit at once; the
//   block takes a word in the first cycle after reset.
//   While rsp_stall is high the pending result holds and no new word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_retire_reorder_buffer_top #(
  parameter int DEPTH    = drrob_pkg::DEPTH_DEF,
  parameter int TAG_BASE = drrob_pkg::TAG_BASE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  drrob_pkg::drrob_req_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output drrob_pkg::drrob_rsp_t rsp
);

  localparam int IW  = $clog2(DEPTH);
  localparam int PW  = $clog2(2 * DEPTH);
  localparam int TAGS = 1 << drrob_pkg::TAG_W;

  // Control state.
  drrob_pkg::drrob_state_t state;
  logic [PW-1:0]           head;
  logic [PW-1:0]           tail;
  logic                    cur_path;
  logic [DEPTH-1:0]        ent_valid;
  logic [DEPTH-1:0]        ent_done;
  logic                    en0;
  logic                    en1;

  // Handshake.
  logic in_acc;
  logic ob_empty;
  logic rsp_pop;

  assign req_stall = !((state == drrob_pkg::ST_IDLE) && ob_empty);
  assign in_acc    = req_valid && !req_stall;
  assign rsp_pop   = rsp_valid && !rsp_stall;

  // Tag to entry index table, worked out at elaboration.
  logic [IW-1:0] tag_idx_lut [TAGS];
  for (genvar g = 0; g < TAGS; g++) begin : g_lut
    localparam int Diff = ((g - TAG_BASE) % DEPTH + DEPTH) % DEPTH;
    assign tag_idx_lut[g] = IW'(Diff);
  end

  // Pointer to index, occupancy and the status fields.
  logic [IW-1:0]                 h0;
  logic [IW-1:0]                 h1;
  logic [IW-1:0]                 t_idx;
  logic [IW-1:0]                 wb_idx;
  logic [PW:0]                   occ;
  logic                          stall_flag;
  logic [drrob_pkg::OCC_W-1:0]   occ_out;

  assign h0     = (head >= PW'(DEPTH)) ? IW'(head - PW'(DEPTH)) : IW'(head);
  assign h1     = (h0 == IW'(DEPTH - 1)) ? '0 : IW'(h0 + IW'(1));
  assign t_idx  = (tail >= PW'(DEPTH)) ? IW'(tail - PW'(DEPTH)) : IW'(tail);
  assign wb_idx = tag_idx_lut[req.wb_tag];

  always_comb begin
    if (tail >= head) begin
      occ = {1'b0, tail} - {1'b0, head};
    end else begin
      occ = {1'b0, tail} + (PW+1)'(2 * DEPTH) - {1'b0, head};
    end
  end

  assign stall_flag = (occ > (PW+1)'(DEPTH - 2));
  assign occ_out    = drrob_pkg::OCC_W'(occ);

  // Tags of the tail and the head pair.
  logic [7:0] t_sum;
  logic [7:0] h0_sum;
  logic [7:0] h1_sum;

  assign t_sum  = 8'(t_idx) + 8'(TAG_BASE);
  assign h0_sum = 8'(h0) + 8'(TAG_BASE);
  assign h1_sum = 8'(h1) + 8'(TAG_BASE);

  // Entry memories: fields fixed at allocation, and the taken bit.
  drrob_pkg::drrob_ent_t ent_wdata;
  drrob_pkg::drrob_ent_t ent0;
  drrob_pkg::drrob_ent_t ent1;
  logic                  alloc_we;
  logic                  taken_we;
  logic                  tk0;
  logic                  tk1;

  assign alloc_we  = in_acc && (req.op == drrob_pkg::OP_ALLOC);
  assign taken_we  = in_acc && (req.op == drrob_pkg::OP_WB) && ent_valid[wb_idx];
  assign ent_wdata = '{wr:   req.writes_register,
                       br:   req.is_branch_instr,
                       st:   req.is_store_instr,
                       path: req.path_tag,
                       rd:   req.dest_reg};

  drrob_ram #(
    .WIDTH ($bits(drrob_pkg::drrob_ent_t)),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk     (clk),
    .we      (alloc_we),
    .waddr   (t_idx),
    .wdata   (ent_wdata),
    .raddr_a (h0),
    .rdata_a (ent0),
    .raddr_b (h1),
    .rdata_b (ent1)
  );

  drrob_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_taken_ram (
    .clk     (clk),
    .we      (taken_we),
    .waddr   (wb_idx),
    .wdata   (req.taken_flag),
    .raddr_a (h0),
    .rdata_a (tk0),
    .raddr_b (h1),
    .rdata_b (tk1)
  );

  // Retire decision on the head pair read from memory.
  logic v0, v1, rdy0, rdy1, onp0, onp1, after0, after1, c0, c1;

  always_comb begin
    v0     = ent_valid[h0];
    v1     = ent_valid[h1];
    rdy0   = v0 && ent_done[h0];
    rdy1   = rdy0 && v1 && ent_done[h1];
    onp0   = !v0 || (ent0.path == cur_path);
    after0 = (rdy0 && onp0 && ent0.br) ? tk0 : cur_path;
    onp1   = !v1 || (ent1.path == after0);
    after1 = (rdy1 && onp1 && ent1.br) ? tk1 : after0;
    c0     = en0 && rdy0 && onp0;
    c1     = en1 && rdy1 && onp1;
  end

  // Result words.
  logic                  push1;
  logic                  push2;
  drrob_pkg::drrob_rsp_t w0;
  drrob_pkg::drrob_rsp_t w1;

  always_comb begin
    w0             = '0;
    w0.stall_res   = stall_flag;
    w0.occupancy   = occ_out;
    w0.active_path = cur_path;
    w0.last        = 1'b1;
    w1             = w0;
    push1          = 1'b0;
    push2          = 1'b0;
    if (state == drrob_pkg::ST_EXEC) begin
      push2               = 1'b1;
      w0.last             = 1'b0;
      w0.committed        = c0;
      w0.can_retire       = rdy0;
      w0.rob_tag          = h0_sum[drrob_pkg::TAG_W-1:0];
      w0.commit_reg       = c0 ? ent0.rd : '0;
      w0.rename_commit_en = c0 && ent0.wr;
      w0.store_release_en = c0 && ent0.st;
      w0.branch_commit_en = c0 && ent0.br;
      w0.path_select      = c0 && tk0;
      w1.committed        = c1;
      w1.can_retire       = rdy1;
      w1.rob_tag          = h1_sum[drrob_pkg::TAG_W-1:0];
      w1.commit_reg       = c1 ? ent1.rd : '0;
      w1.rename_commit_en = c1 && ent1.wr;
      w1.store_release_en = c1 && ent1.st;
      w1.branch_commit_en = c1 && ent1.br;
      w1.path_select      = c1 && tk1;
    end else if (in_acc && (req.op != drrob_pkg::OP_RETIRE)) begin
      push1 = 1'b1;
      if (req.op == drrob_pkg::OP_ALLOC) begin
        w0.rob_tag = t_sum[drrob_pkg::TAG_W-1:0];
      end
    end
  end

  // Head advance by one or two.
  logic [PW:0] hsum;

  always_comb begin
    hsum = {1'b0, head} + ((c0 && c1) ? (PW+1)'(2) : (PW+1)'(1));
    if (hsum >= (PW+1)'(2 * DEPTH)) begin
      hsum = hsum - (PW+1)'(2 * DEPTH);
    end
  end

  // Sequencer and buffer state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= drrob_pkg::ST_IDLE;
      head      <= '0;
      tail      <= '0;
      cur_path  <= 1'b0;
      ent_valid <= '0;
      ent_done  <= '0;
      en0       <= 1'b0;
      en1       <= 1'b0;
    end else begin
      case (state)
        drrob_pkg::ST_IDLE: begin
          if (in_acc) begin
            case (req.op)
              drrob_pkg::OP_FLUSH: begin
                head      <= '0;
                tail      <= '0;
                cur_path  <= 1'b0;
                ent_valid <= '0;
                ent_done  <= '0;
              end
              drrob_pkg::OP_ALLOC: begin
                ent_valid[t_idx] <= 1'b1;
                ent_done[t_idx]  <= 1'b0;
                tail <= (tail == PW'(2 * DEPTH - 1)) ? '0 : PW'(tail + PW'(1));
              end
              drrob_pkg::OP_WB: begin
                if (ent_valid[wb_idx]) begin
                  ent_done[wb_idx] <= 1'b1;
                end
              end
              drrob_pkg::OP_RETIRE: begin
                en0   <= req.retire_slot0_en;
                en1   <= req.retire_slot1_en;
                state <= drrob_pkg::ST_EXEC;
              end
              default: begin
              end
            endcase
          end
        end
        drrob_pkg::ST_EXEC: begin
          if (c0) begin
            ent_valid[h0] <= 1'b0;
          end
          if (c1) begin
            ent_valid[h1] <= 1'b0;
          end
          if (c0) begin
            head     <= PW'(hsum);
            cur_path <= c1 ? after1 : after0;
          end
          state <= drrob_pkg::ST_IDLE;
        end
        default: begin
          state <= drrob_pkg::ST_IDLE;
        end
      endcase
    end
  end

  drrob_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .push1 (push1),
    .push2 (push2),
    .w0    (w0),
    .w1    (w1),
    .pop   (rsp_pop),
    .valid (rsp_valid),
    .word  (rsp),
    .empty (ob_empty)
  );

  `DRROB_CHECK(a_retire_exec, in_acc && (req.op == drrob_pkg::OP_RETIRE) |=> state == drrob_pkg::ST_EXEC, "retire word did not enter the decision cycle")
  `DRROB_CHECK(a_exec_two, state == drrob_pkg::ST_EXEC |=> rsp_valid, "retire produced no result")
  `DRROB_NEVER(a_slot1_alone_head, (state == drrob_pkg::ST_EXEC) && c1 && !rdy0, "second slot ready without the first")
  `DRROB_CHECK(a_commit_clears, (state == drrob_pkg::ST_EXEC) && c0 |=> !ent_valid[$past(h0)], "committed head entry still valid")

endmodule
